/* hdl/pdo_pkg.sv */
// Shared constants for the periodic distance and offset core.
// Register indexes and boundary mode codes; no dependencies.
`default_nettype none

package pdo_pkg;

  localparam int unsigned CFG_IDX_BITS = 2;

  localparam logic [CFG_IDX_BITS-1:0] REG_MODE   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SIDE_X = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_SIDE_Y = 2'd2;

  localparam logic MODE_EDGE  = 1'b0;
  localparam logic MODE_TORUS = 1'b1;

endpackage

`default_nettype wire

/* hdl/pdo_axis.sv */
// One axis of the front end: minimum-image span and wrapped offset.
// Combinational; uses the mode codes of pdo_pkg.
`default_nettype none

module pdo_axis #(
  parameter int unsigned COORD_BITS = 32
) (
  input  logic                  mode_i,
  input  logic [COORD_BITS-1:0] side_i,
  input  logic [COORD_BITS-1:0] p1_i,
  input  logic [COORD_BITS-1:0] p2_i,
  output logic [COORD_BITS-1:0] span_o,
  output logic [COORD_BITS+1:0] ofs_o
);

  logic                  wrap;
  logic [COORD_BITS-1:0] diff;
  logic [COORD_BITS:0]   s_pos;
  logic [COORD_BITS:0]   s_neg;
  logic                  shift_dn;
  logic                  shift_up;

  assign wrap  = (mode_i == pdo_pkg::MODE_TORUS);
  assign diff  = (p1_i > p2_i) ? (p1_i - p2_i) : (p2_i - p1_i);
  assign s_pos = {1'b0, p2_i} - {1'b0, p1_i};
  assign s_neg = {1'b0, p1_i} - {1'b0, p2_i};

  assign shift_dn = wrap && ($signed({s_pos, 1'b0}) > $signed({2'b00, side_i}));
  assign shift_up = wrap && ($signed({s_neg, 1'b0}) > $signed({2'b00, side_i}));

  always_comb begin
    if (wrap && ({diff, 1'b0} > {1'b0, side_i})) begin
      span_o = (side_i >= diff) ? (side_i - diff) : (diff - side_i);
    end else begin
      span_o = diff;
    end
  end

  always_comb begin
    priority if (shift_dn) begin
      ofs_o = {2'b00, p2_i} - {2'b00, side_i};
    end else if (shift_up) begin
      ofs_o = {2'b00, p2_i} + {2'b00, side_i};
    end else begin
      ofs_o = {2'b00, p2_i};
    end
  end

endmodule

`default_nettype wire

/* hdl/pdo_sqrt_cell.sv */
// One cell of the square-root chain: resolves one root bit per beat.
// Carries operand, partial remainder, partial root and side data to the next cell.
`default_nettype none

module pdo_sqrt_cell #(
  parameter int unsigned ROOT_W = 33,
  parameter int unsigned PASS_W = 68
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [2*ROOT_W-1:0] op_i,
  input  logic [ROOT_W+1:0]   rem_i,
  input  logic [ROOT_W-1:0]   root_i,
  input  logic [PASS_W-1:0]   pass_i,
  output logic                valid_o,
  output logic [2*ROOT_W-1:0] op_o,
  output logic [ROOT_W+1:0]   rem_o,
  output logic [ROOT_W-1:0]   root_o,
  output logic [PASS_W-1:0]   pass_o
);

  localparam int unsigned OP_W  = 2 * ROOT_W;
  localparam int unsigned REM_W = ROOT_W + 2;

  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;
  logic              take;
  logic [REM_W-1:0]  rem_d;
  logic [ROOT_W-1:0] root_d;

  assign rem_sh = {rem_i[REM_W-3:0], op_i[OP_W-1:OP_W-2]};
  assign trial  = {root_i, 2'b01};
  assign take   = (rem_sh >= trial);
  assign rem_d  = take ? (rem_sh - trial) : rem_sh;
  assign root_d = {root_i[ROOT_W-2:0], take};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op_o   <= {op_i[OP_W-3:0], 2'b00};
      rem_o  <= rem_d;
      root_o <= root_d;
      pass_o <= pass_i;
    end
  end

endmodule

`default_nettype wire

/* hdl/pdo_out_buf.sv */
// Output register with skid entry; frees the pipeline from the sink's tready.
// Standalone, no package use.
`default_nettype none

module pdo_out_buf #(
  parameter int unsigned W = 104
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  output logic         en_o,
  input  logic         valid_i,
  input  logic [W-1:0] data_i,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [W-1:0] m_axis_tdata
);

  logic         out_valid_q;
  logic [W-1:0] out_data_q;
  logic         skid_valid_q;
  logic [W-1:0] skid_data_q;
  logic         hold;

  assign en_o          = !skid_valid_q;
  assign hold          = out_valid_q && !m_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (hold) begin
      if (!skid_valid_q && valid_i) begin
        skid_valid_q <= 1'b1;
      end
    end else if (skid_valid_q) begin
      out_valid_q  <= 1'b1;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hold) begin
      if (!skid_valid_q && valid_i) begin
        skid_data_q <= data_i;
      end
    end else if (skid_valid_q) begin
      out_data_q <= skid_data_q;
    end else begin
      out_data_q <= data_i;
    end
  end

endmodule

`default_nettype wire

/* hdl/periodic_distance_and_offset_core.sv */
// Minimum-image distance and wrapped offset between two 2-D points, one pair per
// cycle: span and offset stage, square stage, sum stage, a chain of COORD_BITS+1
// square-root cells that each settle one bit of the distance, and the output
// register. The sqrt cell chain is the longest part of the pipeline; throughput is
// one beat per cycle whenever the sink takes results. Configuration registers are
// written through a plain write port.
// Depends on pdo_pkg, pdo_axis, pdo_sqrt_cell and pdo_out_buf.
`default_nettype none

module periodic_distance_and_offset_core #(
  parameter int unsigned COORD_BITS = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [pdo_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [COORD_BITS-1:0]             cfg_wdata_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // first_x, first_y, second_x, second_y, zero pad
  input  logic [((4*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // separation, offset_x, offset_y, zero pad
  output logic [((3*COORD_BITS+5+7)/8)*8-1:0] m_axis_tdata
);

  localparam int unsigned N       = COORD_BITS;
  localparam int unsigned ROOT_W  = N + 1;
  localparam int unsigned OP_W    = 2 * ROOT_W;
  localparam int unsigned REM_W   = ROOT_W + 2;
  localparam int unsigned OFS_W   = N + 2;
  localparam int unsigned PASS_W  = 2 * OFS_W;
  localparam int unsigned OUT_W   = ROOT_W + PASS_W;
  localparam int unsigned OUT_TW  = ((OUT_W + 7) / 8) * 8;
  localparam logic [N-1:0] SIDE_RST = N'(32'd65536);

  logic         mode_q;
  logic [N-1:0] side_x_q;
  logic [N-1:0] side_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= pdo_pkg::MODE_TORUS;
      side_x_q <= SIDE_RST;
      side_y_q <= SIDE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pdo_pkg::REG_MODE:   mode_q   <= cfg_wdata_i[0];
        pdo_pkg::REG_SIDE_X: side_x_q <= cfg_wdata_i;
        pdo_pkg::REG_SIDE_Y: side_y_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic en;
  assign s_axis_tready = en;

  logic [N-1:0]     span_x, span_y;
  logic [OFS_W-1:0] ofs_x, ofs_y;

  pdo_axis #(.COORD_BITS(N)) u_axis_x (
    .mode_i (mode_q),
    .side_i (side_x_q),
    .p1_i   (s_axis_tdata[N-1:0]),
    .p2_i   (s_axis_tdata[3*N-1:2*N]),
    .span_o (span_x),
    .ofs_o  (ofs_x)
  );

  pdo_axis #(.COORD_BITS(N)) u_axis_y (
    .mode_i (mode_q),
    .side_i (side_y_q),
    .p1_i   (s_axis_tdata[2*N-1:N]),
    .p2_i   (s_axis_tdata[4*N-1:3*N]),
    .span_o (span_y),
    .ofs_o  (ofs_y)
  );

  logic              a_valid_q, b_valid_q, c_valid_q;
  logic [N-1:0]      a_span_x_q, a_span_y_q;
  logic [PASS_W-1:0] a_pass_q, b_pass_q, c_pass_q;
  logic [2*N-1:0]    b_sq_x_q, b_sq_y_q;
  logic [2*N:0]      c_sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else if (en) begin
      a_valid_q <= s_axis_tvalid;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_span_x_q <= span_x;
      a_span_y_q <= span_y;
      a_pass_q   <= {ofs_y, ofs_x};
      b_sq_x_q   <= a_span_x_q * a_span_x_q;
      b_sq_y_q   <= a_span_y_q * a_span_y_q;
      b_pass_q   <= a_pass_q;
      c_sum_q    <= {1'b0, b_sq_x_q} + {1'b0, b_sq_y_q};
      c_pass_q   <= b_pass_q;
    end
  end

  logic              cv    [ROOT_W+1];
  logic [OP_W-1:0]   cop   [ROOT_W+1];
  logic [REM_W-1:0]  crem  [ROOT_W+1];
  logic [ROOT_W-1:0] croot [ROOT_W+1];
  logic [PASS_W-1:0] cpass [ROOT_W+1];

  assign cv[0]    = c_valid_q;
  assign cop[0]   = {1'b0, c_sum_q};
  assign crem[0]  = '0;
  assign croot[0] = '0;
  assign cpass[0] = c_pass_q;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_cell
    pdo_sqrt_cell #(.ROOT_W(ROOT_W), .PASS_W(PASS_W)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (cv[k]),
      .op_i    (cop[k]),
      .rem_i   (crem[k]),
      .root_i  (croot[k]),
      .pass_i  (cpass[k]),
      .valid_o (cv[k+1]),
      .op_o    (cop[k+1]),
      .rem_o   (crem[k+1]),
      .root_o  (croot[k+1]),
      .pass_o  (cpass[k+1])
    );
  end

  logic [OUT_TW-1:0] res_beat;
  assign res_beat = {{(OUT_TW-OUT_W){1'b0}}, cpass[ROOT_W], croot[ROOT_W]};

  pdo_out_buf #(.W(OUT_TW)) u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_o          (en),
    .valid_i       (cv[ROOT_W]),
    .data_i        (res_beat),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

`default_nettype wire

/* tb/tb_periodic_distance_and_offset_core.sv */
// Self-checking testbench for periodic_distance_and_offset_core: minimum-image distance
// and wrapped offset of point pairs, predicted per beat and checked in order.
// Depends on pdo_pkg and the core RTL.
`default_nettype none

module tb_periodic_distance_and_offset_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned COORD_BITS = 32;
  localparam int unsigned IN_W = ((4*COORD_BITS+7)/8)*8;
  localparam int unsigned OUT_W = ((3*COORD_BITS+5+7)/8)*8;
  localparam logic [pdo_pkg::CFG_IDX_BITS-1:0] REG_UNUSED = 2'd3;
  localparam int unsigned SINK_HOLD_CYCLES = 300;
  localparam int unsigned IDLE_LIMIT = 5000;
  localparam int unsigned TAIL_CYCLES = 45;

  typedef struct packed {
    logic [33:0] offset_y;
    logic [33:0] offset_x;
    logic [32:0] separation;
  } pair_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [pdo_pkg::CFG_IDX_BITS-1:0] cfg_idx_i = '0;
  logic [COORD_BITS-1:0] cfg_wdata_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // first_x, first_y, second_x, second_y
  logic [IN_W-1:0]       s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // separation, offset_x, offset_y, zero pad
  logic [OUT_W-1:0]      m_axis_tdata;

  logic                  torus_mode = pdo_pkg::MODE_TORUS;
  logic [31:0]           side_x = 32'd65536;
  logic [31:0]           side_y = 32'd65536;

  pair_result_t          pending_results[$];
  int unsigned           error_count = 0;
  bit                    src_eager = 1'b0;
  bit                    snk_eager = 1'b0;
  int unsigned           hold_requests = 0;
  int unsigned           hold_served = 0;
  int unsigned           snk_wait = 0;
  int unsigned           idle_cycles = 0;

  periodic_distance_and_offset_core #(
    .COORD_BITS(COORD_BITS)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [31:0] wrapped_gap(input logic [31:0] a, input logic [31:0] b,
                                              input logic [31:0] side, input logic wrap);
    logic [31:0] d;
    d = (a > b) ? a - b : b - a;
    if (wrap && ({d, 1'b0} > {1'b0, side})) begin
      return (side >= d) ? side - d : d - side;
    end
    return d;
  endfunction

  function automatic logic [33:0] shifted_coord(input logic [31:0] p1, input logic [31:0] p2,
                                                input logic [31:0] side, input logic wrap);
    longint diff;
    longint pos;
    longint span;
    diff = longint'({32'b0, p2}) - longint'({32'b0, p1});
    pos  = longint'({32'b0, p2});
    span = longint'({32'b0, side});
    if (wrap) begin
      if (2 * diff > span) pos = longint'({32'b0, p2}) - span;
      if (-2 * diff > span) pos = longint'({32'b0, p2}) + span;
    end
    return pos[33:0];
  endfunction

  function automatic logic [32:0] floor_root(input logic [64:0] radicand);
    logic [32:0] root;
    logic [65:0] trial;
    logic [65:0] radicand_w;
    root = '0;
    radicand_w = {1'b0, radicand};
    for (int i = 32; i >= 0; i--) begin
      trial = {33'b0, root | (33'd1 << i)};
      if (trial * trial <= radicand_w) root = trial[32:0];
    end
    return root;
  endfunction

  function automatic pair_result_t predict_pair(input logic [31:0] x1, input logic [31:0] y1,
                                                input logic [31:0] x2, input logic [31:0] y2);
    pair_result_t res;
    logic [64:0] gx;
    logic [64:0] gy;
    gx = {33'b0, wrapped_gap(x1, x2, side_x, torus_mode)};
    gy = {33'b0, wrapped_gap(y1, y2, side_y, torus_mode)};
    res.separation = floor_root(gx * gx + gy * gy);
    res.offset_x   = shifted_coord(x1, x2, side_x, torus_mode);
    res.offset_y   = shifted_coord(y1, y2, side_y, torus_mode);
    return res;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    pair_result_t want;
    pair_result_t got;
    if (m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[$bits(pair_result_t)-1:0];
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, got);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.separation !== want.separation) begin
          $display("%0t: separation expected %h, got %h", $time, want.separation,
                   got.separation);
          error_count++;
        end
        if (got.offset_x !== want.offset_x) begin
          $display("%0t: offset_x expected %h, got %h", $time, want.offset_x, got.offset_x);
          error_count++;
        end
        if (got.offset_y !== want.offset_y) begin
          $display("%0t: offset_y expected %h, got %h", $time, want.offset_y, got.offset_y);
          error_count++;
        end
      end
    end
  end

  // result sink with random stalls and a long hold on request
  always @(posedge clk_i) begin
    int unsigned roll;
    if (snk_wait != 0) begin
      snk_wait--;
      m_axis_tready <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      snk_wait = SINK_HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (snk_eager) begin
      m_axis_tready <= 1'b1;
    end else begin
      roll = $urandom_range(0, 19);
      if (roll < 14) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b0;
        snk_wait = (roll < 19) ? $urandom_range(0, 2) : $urandom_range(10, 40);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no beat accepted for %0d cycles", $time, IDLE_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic send_pair(input logic [31:0] x1, input logic [31:0] y1,
                           input logic [31:0] x2, input logic [31:0] y2);
    int unsigned gap;
    int unsigned roll;
    gap = 0;
    if (!src_eager) begin
      roll = $urandom_range(0, 19);
      if (roll >= 19) gap = $urandom_range(8, 30);
      else if (roll >= 13) gap = $urandom_range(1, 3);
    end
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {y2, x2, y1, x1};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_results.push_back(predict_pair(x1, y1, x2, y2));
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_beat(input logic [pdo_pkg::CFG_IDX_BITS-1:0] idx,
                          input logic [31:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
  endtask

  task automatic apply_config(input logic [31:0] mode_word, input logic [31:0] sx,
                              input logic [31:0] sy, input bit with_junk);
    wait_drained();
    if (with_junk) cfg_beat(REG_UNUSED, $urandom);
    cfg_beat(pdo_pkg::REG_MODE, mode_word);
    cfg_beat(pdo_pkg::REG_SIDE_X, sx);
    cfg_beat(pdo_pkg::REG_SIDE_Y, sy);
    cfg_we_i <= 1'b0;
    torus_mode = mode_word[0];
    side_x = sx;
    side_y = sy;
  endtask

  function automatic void pick_axis(input logic [31:0] side, output logic [31:0] a,
                                    output logic [31:0] b);
    int unsigned kind;
    logic [31:0] t;
    kind = $urandom_range(0, 9);
    a = $urandom;
    b = $urandom;
    if (kind <= 5 && side != 0) begin
      a = a % side;
      b = b % side;
    end else if (kind == 7) begin
      b = a + (side >> 1) + $urandom_range(0, 1);
      if ($urandom_range(0, 1) != 0) begin
        t = a;
        a = b;
        b = t;
      end
    end else if (kind == 8) begin
      a = ($urandom_range(0, 1) != 0) ? '1 : '0;
      b = ($urandom_range(0, 1) != 0) ? '1 : '0;
    end else if (kind == 9) begin
      b = a;
    end
  endfunction

  task automatic send_random_pair();
    logic [31:0] x1, x2, y1, y2;
    pick_axis(side_x, x1, x2);
    pick_axis(side_y, y1, y2);
    send_pair(x1, y1, x2, y2);
  endtask

  task automatic test_reset_defaults();
    send_pair(32'h0, 32'h0, 32'h0, 32'h0);
    send_pair(32'h0, 32'h0, 32'h8000, 32'h8000);
    send_pair(32'h0, 32'h0, 32'h8001, 32'h8001);
    send_pair(32'h8001, 32'h8001, 32'h0, 32'h0);
    send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0);
    send_pair(32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  task automatic test_edge_mode();
    apply_config(32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1);
    send_pair(32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0);
    send_pair(32'h1234_5678, 32'h0, 32'h8765_4321, 32'hFFFF_FFFF);
  endtask

  task automatic test_zero_side();
    apply_config({31'h7FFF_FFFF, pdo_pkg::MODE_TORUS}, 32'h0, 32'h0, 1'b0);
    send_pair(32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 32'h0002_0000);
    send_pair(32'h0, 32'h0003_0000, 32'h0004_0000, 32'h0);
    send_pair(32'hFFFF_FFFF, 32'h0, 32'h0, 32'hFFFF_FFFF);
  endtask

  task automatic test_full_side();
    apply_config({31'h0, pdo_pkg::MODE_TORUS}, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_pair(32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0);
    send_pair(32'h0, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF);
    send_pair(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0);
  endtask

  task automatic test_backpressure();
    apply_config({31'h0, pdo_pkg::MODE_TORUS}, $urandom_range(1, 32'h0040_0000), $urandom,
                 1'b0);
    src_eager = 1'b1;
    hold_requests++;
    repeat (80) send_random_pair();
    src_eager = 1'b0;
  endtask

  task automatic test_random_phases();
    logic [31:0] mode_word;
    logic [31:0] sx;
    logic [31:0] sy;
    for (int phase = 0; phase < 6; phase++) begin
      mode_word = $urandom;
      mode_word[0] = (phase == 2) ? pdo_pkg::MODE_EDGE : pdo_pkg::MODE_TORUS;
      sx = $urandom;
      sy = $urandom;
      unique case (phase)
        0, 5: begin
          sx = $urandom_range(1, 32'h0010_0000);
          sy = $urandom_range(1, 32'h0010_0000);
        end
        3: sx = '0;
        4: sx = '1;
        default: ;
      endcase
      apply_config(mode_word, sx, sy, phase == 5);
      src_eager = (phase == 1) || (phase == 5);
      snk_eager = (phase == 3) || (phase == 5);
      repeat (90) send_random_pair();
      src_eager = 1'b0;
      snk_eager = 1'b0;
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_edge_mode();
    test_zero_side();
    test_full_side();
    test_backpressure();
    test_random_phases();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
